### src/binomial_via_prime_exponents_core_defines.svh
// Assertion macros for the binomial core.
`ifndef BINOMIAL_VIA_PRIME_EXPONENTS_CORE_DEFINES_SVH
`define BINOMIAL_VIA_PRIME_EXPONENTS_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define BPE_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define BPE_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### src/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Types and constants shared by the binomial core.
// ----------------------------------------------------------------------------
package bpe_pkg;
  localparam int unsigned MaxNDefault  = 1024;
  localparam logic [30:0] ModulusReset = 31'd1000000007;

  typedef struct packed {
    logic [10:0] n_value;
    logic [10:0] r_value;
  } bpe_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        r_exceeds_n;
  } bpe_out_t;

  typedef enum logic [3:0] {
    StSieveInit, StSieveScan, StSieveMark, StIdle, StClear, StFactRd,
    StFactUpd, StMulRd, StMulGo, StMulWait, StDone
  } bpe_state_e;

  // Control from the sequencer into the modular multiplier.
  typedef struct packed {
    logic        start;
    logic        wrap;
  } bpe_mul_ctl_t;
endpackage

### src/binomial_via_prime_exponents_core.sv
// ----------------------------------------------------------------------------
// binomial_via_prime_exponents_core
// Binomial coefficient C(n, r) from prime exponents, reduced by a modulus (kept modulo 2^64 when it is zero).
// ----------------------------------------------------------------------------
// After reset the core fills a smallest-prime-factor table by a sieve
// with busy high; configuration writes are still taken. Each table entry also
// holds the cofactor index/spf, so the factor walk needs no divider. A query
// is accepted when start is high and busy low. It then clears the exponent
// store, walks the integers and their prime factors (the add and subtract
// walks share one store), then takes each candidate from 2 up to n through
// the shift-add modular multiplier once per unit of exponent (a plain 64-bit
// product when the modulus is zero). A query with r > n gives its result in
// the cycle after acceptance. The result is driven for one cycle with
// result_valid_o and must be taken then: the receiver cannot stall.
module binomial_via_prime_exponents_core import bpe_pkg::*; #(
  parameter int unsigned MAX_N = MaxNDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bpe_in_t     in_i,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  output logic        result_valid_o,
  output bpe_out_t    out_o
);
`include "binomial_via_prime_exponents_core_defines.svh"
  localparam int unsigned AW = $clog2(MAX_N + 1);
  localparam int unsigned EW = AW + 1;

  bpe_state_e st_q, st_d;
  logic [30:0]     mod_q;
  // entry: {cofactor, smallest prime factor}
  logic [2*AW-1:0] spf_mem [MAX_N+1];
  logic [EW-1:0]   exp_mem [MAX_N+1];
  logic [2*AW-1:0] spf_rd;
  logic [EW-1:0]   exp_rd;
  logic [AW:0]   i_q, i_d, j_q, j_d, v_q, v_d, n_q, n_d, r_q, r_d, nr_q, nr_d;
  logic [AW:0]   c_q, c_d;           // multiple index while marking
  logic          phase_q, phase_d;   // 0: add walk, 1: subtract walk
  logic [EW-1:0] k_q, k_d;
  logic [63:0]   prod_q, prod_d;
  logic          rex_q, rex_d, ov_q, ov_d;
  logic [AW:0]   ns, rs;
  // store port controls
  logic            spf_we, exp_we;
  logic [AW-1:0]   spf_wa, spf_ra, exp_wa, exp_ra;
  logic [2*AW-1:0] spf_wd;
  logic [EW-1:0]   exp_wd;
  bpe_mul_ctl_t  mctl;
  logic [63:0]   mp;
  logic          mdone;
  logic [AW-1:0] p;
  logic [AW-1:0] cof;

  localparam logic [AW:0] MaxV = (AW+1)'(MAX_N);

  always_ff @(posedge clk_i) begin
    if (spf_we) spf_mem[spf_wa] <= spf_wd;
    spf_rd <= spf_mem[spf_ra];
    if (exp_we) exp_mem[exp_wa] <= exp_wd;
    exp_rd <= exp_mem[exp_ra];
  end

  bpe_modmul #(.FW(AW + 1)) u_mul (
    .clk_i, .rst_ni, .ctl_i(mctl), .a_i(prod_q), .b_i(i_q), .m_i(mod_q),
    .p_o(mp), .done_o(mdone)
  );

  // saturate the inputs to MAX_N
  always_comb begin
    ns = (in_i.n_value > 11'(MAX_N)) ? MaxV : (AW+1)'(in_i.n_value);
    rs = (in_i.r_value > 11'(MAX_N)) ? MaxV : (AW+1)'(in_i.r_value);
  end

  assign p   = spf_rd[AW-1:0];
  assign cof = spf_rd[2*AW-1:AW];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StSieveInit: if (i_q == MaxV) st_d = StSieveScan;
      StSieveScan: begin
        if (i_q > MaxV) st_d = StIdle;
        else if (ov_q && (AW+1)'(p) == j_q) st_d = StSieveMark;
      end
      StSieveMark: if (v_q > MaxV) st_d = StSieveScan;
      StIdle:      if (start) st_d = (rs > ns) ? StDone : StClear;
      StClear:     if (i_q == MaxV) st_d = StFactRd;
      StFactRd: begin
        if (v_q < 2) begin
          if (phase_q && j_q < 2) st_d = StMulRd;
        end else st_d = StFactUpd;
      end
      StFactUpd:   if (ov_q) st_d = StFactRd;
      StMulRd: begin
        if (i_q > n_q) st_d = StDone;
        else if (ov_q) st_d = StMulGo;
      end
      StMulGo:     st_d = (k_q == '0 || k_q[EW-1]) ? StMulRd : StMulWait;
      StMulWait:   if (mdone) st_d = StMulGo;
      StDone:      st_d = StIdle;
      default:     st_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    i_d = i_q; j_d = j_q; v_d = v_q; n_d = n_q; r_d = r_q; nr_d = nr_q; c_d = c_q;
    phase_d = phase_q; k_d = k_q; prod_d = prod_q; rex_d = rex_q; ov_d = 1'b0;
    spf_we = 1'b0; spf_wa = i_q[AW-1:0]; spf_wd = {AW'(1), i_q[AW-1:0]};
    spf_ra = i_q[AW-1:0];
    exp_we = 1'b0; exp_wa = i_q[AW-1:0]; exp_wd = '0; exp_ra = i_q[AW-1:0];
    mctl = '0;
    case (st_q)
      StSieveInit: begin
        spf_we = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q == MaxV) begin i_d = (AW+1)'(2); end
        j_d = (AW+1)'(2);
      end
      StSieveScan: begin
        // read spf[i]; compare it in the next cycle with i (held in j)
        spf_ra = i_q[AW-1:0];
        if (ov_q && (AW+1)'(p) == j_q) begin
          v_d = j_q + j_q; c_d = (AW+1)'(2);
        end else if (i_q <= MaxV) begin
          j_d = i_q; i_d = i_q + 1'b1; ov_d = 1'b1;
        end
      end
      StSieveMark: begin
        // multiples of prime j: read then write if larger
        spf_ra = v_q[AW-1:0];
        if (v_q <= MaxV) begin
          if (ov_q) begin
            if ((AW+1)'(p) > j_q) begin
              spf_we = 1'b1; spf_wa = v_q[AW-1:0];
              spf_wd = {c_q[AW-1:0], j_q[AW-1:0]};
            end
            v_d = v_q + j_q; c_d = c_q + 1'b1;
          end else ov_d = 1'b1;
          spf_ra = v_q[AW-1:0];
        end
        if (ov_q && v_q <= MaxV) ov_d = 1'b0;
      end
      StIdle: begin
        if (start) begin
          n_d = ns; r_d = rs; rex_d = (rs > ns); i_d = '0;
          nr_d = ns - rs;
        end
      end
      StClear: begin
        exp_we = 1'b1; exp_wa = i_q[AW-1:0]; exp_wd = '0;
        i_d = i_q + 1'b1;
        if (i_q == MaxV) begin
          j_d = n_q; phase_d = 1'b0; v_d = '0;
        end
      end
      StFactRd: begin
        // v holds the value being factored; j the next integer of the walk
        if (v_q < 2) begin
          if (!phase_q) begin
            if (j_q > r_q) begin v_d = j_q; j_d = j_q - 1'b1; end
            else begin phase_d = 1'b1; j_d = nr_q; end
          end else if (j_q >= 2) begin
            v_d = j_q; j_d = j_q - 1'b1;
          end else begin
            i_d = (AW+1)'(2); prod_d = (mod_q != '0) ? ((mod_q == 31'd1) ? 64'd0 : 64'd1)
                                                  : 64'd1;
          end
        end else spf_ra = v_q[AW-1:0];
      end
      StFactUpd: begin
        spf_ra = v_q[AW-1:0];
        exp_ra = p;
        if (!ov_q) ov_d = 1'b1;
        else begin
          exp_we = 1'b1; exp_wa = p;
          exp_wd = phase_q ? exp_rd - 1'b1 : exp_rd + 1'b1;
          // advance to the cofactor held beside the smallest factor
          v_d = (AW+1)'(cof);
        end
      end
      StMulRd: begin
        exp_ra = i_q[AW-1:0];
        if (i_q <= n_q) begin
          if (ov_q) k_d = exp_rd;
          else ov_d = 1'b1;
        end
      end
      StMulGo: begin
        if (k_q == '0 || k_q[EW-1]) i_d = i_q + 1'b1;
        else begin
          mctl.start = 1'b1; mctl.wrap = (mod_q == '0);
          k_d = k_q - 1'b1;
        end
      end
      StMulWait: if (mdone) prod_d = mp;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StSieveInit; mod_q <= ModulusReset; i_q <= '0; ov_q <= 1'b0;
      j_q <= '0; v_q <= '0; c_q <= '0; phase_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; i_q <= i_d; j_q <= j_d; phase_q <= phase_d;
      v_q <= v_d; c_q <= c_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; nr_q <= nr_d; k_q <= k_d; prod_q <= prod_d; rex_q <= rex_d;
  end

  assign busy           = (st_q != StIdle);
  assign result_valid_o = (st_q == StDone);
  assign out_o.result      = rex_q ? 64'd0 : prod_q;
  assign out_o.r_exceeds_n = rex_q;

  `BPE_ASSERT_IMP(a_done_idle, clk_i, rst_ni, result_valid_o, busy)
  `BPE_ASSERT_NEXT(a_done_next, clk_i, rst_ni, result_valid_o, !busy)
  `BPE_ASSERT_IMP(a_rex_zero, clk_i, rst_ni, result_valid_o && rex_q, out_o.result == '0)
endmodule

### src/bpe_modmul.sv
// ----------------------------------------------------------------------------
// bpe_modmul
// Product times a small factor, reduced by shift-and-subtract, one bit a cycle (unreduced on wrap).
// ----------------------------------------------------------------------------
module bpe_modmul import bpe_pkg::*; #(
  parameter int unsigned FW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpe_mul_ctl_t  ctl_i,
  input  logic [63:0]   a_i,
  input  logic [FW-1:0] b_i,
  input  logic [30:0]   m_i,
  output logic [63:0]   p_o,
  output logic          done_o
);
  localparam int unsigned CW = $clog2(FW + 1);
  logic [63:0]   acc_q, acc_d;
  logic [FW-1:0] b_q, b_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [33:0]   dbl, add;
  logic [33:0]   m_ext;

  assign m_ext = {3'b0, m_i};

  always_comb begin
    acc_d = acc_q; b_d = b_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    dbl = '0; add = '0;
    if (ctl_i.start) begin
      if (ctl_i.wrap) begin
        acc_d  = a_i * {{(64-FW){1'b0}}, b_i};
        done_d = 1'b1;
      end else begin
        acc_d = '0; b_d = b_i; cnt_d = CW'(FW); busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // acc = 2*acc + a*bit, kept below m; a is already below m
      dbl = {acc_q[32:0], 1'b0};
      if (dbl >= m_ext) dbl = dbl - m_ext;
      add = dbl + (b_q[FW-1] ? {3'b0, a_i[30:0]} : 34'd0);
      if (add >= m_ext) add = add - m_ext;
      acc_d = {30'b0, add};
      b_d   = {b_q[FW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; b_q <= b_d;
  end

  assign p_o    = acc_q;
  assign done_o = done_q;
endmodule
